[src/lsfcc_pkg.sv]
// Shared types, codes and the colour palette of the fading colour chase block.
package lsfcc_pkg;

  localparam int unsigned StripLengthDefault = 30;
  localparam int unsigned IndexWidth        = 6;
  localparam int unsigned ChanWidth         = 8;
  localparam int unsigned HoldWidth         = 9;
  localparam int unsigned PalIdxWidth       = 3;
  localparam int unsigned CfgIdxWidth       = 1;

  localparam logic [ChanWidth-1:0] FadeStepReset  = 8'd5;
  localparam logic [ChanWidth-1:0] HoldLimitReset = 8'd50;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_RAINBOW = 2'd1,
    REQ_SOLID   = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_FADE_STEP  = 1'd0,
    REG_HOLD_LIMIT = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } pixel_t;

  // controller -> datapath
  typedef struct packed {
    logic apply;  // input word accepted, update strip per request type
    logic step;   // move one pixel into the output register
    logic last;   // this step is the final pixel of the frame
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic pixel_t palette(input logic [PalIdxWidth-1:0] idx);
    pixel_t p;
    case (idx)
      3'd0:    p = '{red: 8'd150, green: 8'd150, blue: 8'd150};
      3'd1:    p = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      3'd2:    p = '{red: 8'd255, green: 8'd100, blue: 8'd0};
      3'd3:    p = '{red: 8'd100, green: 8'd255, blue: 8'd0};
      3'd4:    p = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
      3'd5:    p = '{red: 8'd0,   green: 8'd100, blue: 8'd255};
      3'd6:    p = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      default: p = '{red: 8'd100, green: 8'd0,   blue: 8'd255};
    endcase
    return p;
  endfunction

endpackage

[src/lsfcc_if.sv]
// Request and pixel channel interfaces.
interface lsfcc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] fill_red;
  logic [7:0] fill_green;
  logic [7:0] fill_blue;

  modport source (output valid, req_type, fill_red, fill_green, fill_blue, input ready);
  modport sink   (input valid, req_type, fill_red, fill_green, fill_blue, output ready);
endinterface

interface lsfcc_pix_if;
  logic       valid;
  logic       ready;
  logic [5:0] pixel_index;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       frame_end;

  modport source (output valid, pixel_index, pixel_red, pixel_green, pixel_blue, frame_end,
                  input ready);
  modport sink   (input valid, pixel_index, pixel_red, pixel_green, pixel_blue, frame_end,
                  output ready);
endinterface

[src/lsfcc_ctrl.sv]
// Controller: accepts requests and sequences the frame emission.
module lsfcc_ctrl #(
  parameter int unsigned StripLength = lsfcc_pkg::StripLengthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           req_type_i,
  output logic                 in_ready_o,
  input  lsfcc_pkg::status_t   status_i,
  output lsfcc_pkg::cmd_t      cmd_o,
  output logic [lsfcc_pkg::IndexWidth-1:0] pixel_index_o
);

  localparam int unsigned CntWidth = $clog2(StripLength);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic                state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                accept;
  logic                emits;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign emits      = (req_type_i == lsfcc_pkg::REQ_RAINBOW) ||
                      (req_type_i == lsfcc_pkg::REQ_SOLID);

  always_comb begin
    cmd_o.apply = accept;
    cmd_o.step  = (state_q == StEmit) && status_i.out_free;
    cmd_o.last  = (cnt_q == CntWidth'(StripLength - 1));
  end

  assign pixel_index_o = lsfcc_pkg::IndexWidth'(cnt_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (accept && emits) begin
          state_d = StEmit;
          cnt_d   = '0;
        end
      end
      StEmit: begin
        if (cmd_o.step) begin
          if (cmd_o.last) begin
            state_d = StIdle;
          end else begin
            cnt_d = cnt_q + CntWidth'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[src/lsfcc_dp.sv]
// Datapath: pixel strip, palette sequencing, fade and the output register.
module lsfcc_dp #(
  parameter int unsigned StripLength = lsfcc_pkg::StripLengthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsfcc_pkg::cmd_t      cmd_i,
  output lsfcc_pkg::status_t   status_o,
  input  logic [1:0]           req_type_i,
  input  lsfcc_pkg::pixel_t    fill_i,
  input  logic                 cfg_we_i,
  input  logic [lsfcc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [lsfcc_pkg::ChanWidth-1:0]   cfg_data_i,
  input  logic [lsfcc_pkg::IndexWidth-1:0]  pixel_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [lsfcc_pkg::IndexWidth-1:0]  out_index_o,
  output lsfcc_pkg::pixel_t    out_pixel_o,
  output logic                 out_last_o
);

  localparam int unsigned CW = lsfcc_pkg::ChanWidth;
  localparam int unsigned HW = lsfcc_pkg::HoldWidth;
  localparam int unsigned PW = lsfcc_pkg::PalIdxWidth;

  lsfcc_pkg::pixel_t px_q [StripLength];
  lsfcc_pkg::pixel_t px_d [StripLength];

  logic [CW-1:0] fade_step_q, hold_limit_q;
  logic [HW-1:0] hold_q, hold_d, hold_nxt;
  logic [PW-1:0] pal_q, pal_d, pal_nxt;
  logic          advance;
  lsfcc_pkg::pixel_t target, faded;

  logic                             out_valid_q;
  logic [lsfcc_pkg::IndexWidth-1:0] out_index_q;
  lsfcc_pkg::pixel_t                out_pixel_q;
  logic                             out_last_q;

  // one channel moves by the step towards its target when further than a step away
  function automatic logic [CW-1:0] fade(input logic [CW-1:0] cur,
                                         input logic [CW-1:0] tgt,
                                         input logic [CW-1:0] stp);
    logic [CW:0] c;
    logic [CW:0] t;
    logic [CW:0] s;
    c = {1'b0, cur};
    t = {1'b0, tgt};
    s = {1'b0, stp};
    if ((c + s) < t) c = c + s;
    if (c > (t + s)) c = c - s;
    return c[CW-1:0];
  endfunction

  assign advance  = (hold_q > {1'b0, hold_limit_q});
  assign pal_nxt  = advance ? (pal_q + PW'(1)) : pal_q;
  assign hold_nxt = (advance ? '0 : hold_q) + HW'(1);
  assign target   = lsfcc_pkg::palette(pal_nxt);

  always_comb begin
    faded.red   = fade(px_q[0].red,   target.red,   fade_step_q);
    faded.green = fade(px_q[0].green, target.green, fade_step_q);
    faded.blue  = fade(px_q[0].blue,  target.blue,  fade_step_q);
  end

  always_comb begin
    px_d   = px_q;
    hold_d = hold_q;
    pal_d  = pal_q;
    if (cmd_i.apply) begin
      case (req_type_i)
        lsfcc_pkg::REQ_CLEAR: begin
          for (int i = 0; i < StripLength; i++) px_d[i] = '0;
        end
        lsfcc_pkg::REQ_RAINBOW: begin
          for (int i = 1; i < StripLength; i++) px_d[i] = px_q[i-1];
          px_d[0] = faded;
          hold_d  = hold_nxt;
          pal_d   = pal_nxt;
        end
        lsfcc_pkg::REQ_SOLID: begin
          for (int i = 0; i < StripLength; i++) px_d[i] = fill_i;
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      // rotate so the next pixel reaches the head; a full frame restores the order
      for (int i = 0; i < StripLength - 1; i++) px_d[i] = px_q[i+1];
      px_d[StripLength-1] = px_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StripLength; i++) px_q[i] <= '0;
      hold_q       <= '0;
      pal_q        <= '0;
      fade_step_q  <= lsfcc_pkg::FadeStepReset;
      hold_limit_q <= lsfcc_pkg::HoldLimitReset;
    end else begin
      px_q   <= px_d;
      hold_q <= hold_d;
      pal_q  <= pal_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lsfcc_pkg::REG_FADE_STEP:  fade_step_q  <= cfg_data_i;
          lsfcc_pkg::REG_HOLD_LIMIT: hold_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_index_q <= pixel_index_i;
      out_pixel_q <= px_q[0];
      out_last_q  <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_pixel_o = out_pixel_q;
  assign out_last_o  = out_last_q;

endmodule

[src/led_strip_fading_color_chase_top.sv]
// Top level of the fading colour chase LED strip block.
//
// Channels: req_i takes one request word (clear, rainbow step, solid fill);
// pix_o gives one word per pixel, index 0 first, frame_end on the last.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write fade step (0) and hold
// limit (1); write only while no frame is in flight.
// Frame: after a rainbow or solid request is taken, the controller enters its
// emit state and each pixel word passes through the output register. A frame
// is StripLength words at one word per cycle while the receiver does not
// stall; a clear or unused request yields no pixel words.
// The pixel store is a rotating register line: each emitted word comes from
// its head, and one full frame returns it to strip order.
// req_i.ready is high while no frame is being emitted; a new request may be
// taken while the last pixel word still waits in the output register.
// A receiver stall holds the output word and pauses the rotation.
// Reset clears the strip, hold counter and palette index, loads fade step 5
// and hold limit 50, and leaves both channels idle.
module led_strip_fading_color_chase_top #(
  parameter int unsigned StripLength = lsfcc_pkg::StripLengthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lsfcc_req_if.sink            req_i,
  lsfcc_pix_if.source          pix_o,
  input  logic                 cfg_we_i,
  input  logic [lsfcc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [lsfcc_pkg::ChanWidth-1:0]   cfg_data_i
);

  lsfcc_pkg::cmd_t    cmd;
  lsfcc_pkg::status_t status;
  lsfcc_pkg::pixel_t  fill;
  lsfcc_pkg::pixel_t  out_pixel;
  logic [lsfcc_pkg::IndexWidth-1:0] pixel_index;

  assign fill = '{red: req_i.fill_red, green: req_i.fill_green, blue: req_i.fill_blue};

  lsfcc_ctrl #(
    .StripLength (StripLength)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .req_type_i    (req_i.req_type),
    .in_ready_o    (req_i.ready),
    .status_i      (status),
    .cmd_o         (cmd),
    .pixel_index_o (pixel_index)
  );

  lsfcc_dp #(
    .StripLength (StripLength)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .req_type_i    (req_i.req_type),
    .fill_i        (fill),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_index_i (pixel_index),
    .out_valid_o   (pix_o.valid),
    .out_ready_i   (pix_o.ready),
    .out_index_o   (pix_o.pixel_index),
    .out_pixel_o   (out_pixel),
    .out_last_o    (pix_o.frame_end)
  );

  assign pix_o.pixel_red   = out_pixel.red;
  assign pix_o.pixel_green = out_pixel.green;
  assign pix_o.pixel_blue  = out_pixel.blue;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the fading colour chase strip: directed table, then random phases.
module testbench;
  import lsfcc_pkg::*;

  localparam int unsigned StripLen   = StripLengthDefault;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRows    = 18;

  typedef struct packed {
    logic [IndexWidth-1:0] index;
    pixel_t                colour;
    logic                  frame_end;
  } pixel_word_t;

  // typed rows give the whole frame as a head pixel and one colour for the rest
  typedef struct {
    req_type_e kind;
    pixel_t    fill;
    bit        typed;
    pixel_t    head;
    pixel_t    tail;
  } strip_req_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [ChanWidth-1:0]   cfg_data_i;

  lsfcc_req_if req_bus ();
  lsfcc_pix_if pix_bus ();

  led_strip_fading_color_chase_top #(
    .StripLength(StripLen)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_bus),
    .pix_o     (pix_bus),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  pixel_t palette_colours [8] = '{
    24'h969696, 24'hFF0000, 24'hFF6400, 24'h64FF00,
    24'h00FF00, 24'h0064FF, 24'h0000FF, 24'h6400FF
  };

  strip_req_t chase_table [NumRows] = '{
    '{REQ_RAINBOW, 24'hFFFFFF, 1'b1, 24'h050505, 24'h000000},
    '{REQ_NONE,    24'hFFFFFF, 1'b0, 24'h000000, 24'h000000},
    '{REQ_SOLID,   24'h000000, 1'b1, 24'h000000, 24'h000000},
    '{REQ_SOLID,   24'hFFFFFF, 1'b1, 24'hFFFFFF, 24'hFFFFFF},
    '{REQ_SOLID,   24'hAA55AA, 1'b1, 24'hAA55AA, 24'hAA55AA},
    '{REQ_SOLID,   24'h55AA55, 1'b1, 24'h55AA55, 24'h55AA55},
    '{REQ_RAINBOW, 24'h123456, 1'b0, 24'h000000, 24'h000000},
    '{REQ_RAINBOW, 24'hFEDCBA, 1'b0, 24'h000000, 24'h000000},
    '{REQ_CLEAR,   24'hFFFFFF, 1'b0, 24'h000000, 24'h000000},
    '{REQ_RAINBOW, 24'h000000, 1'b1, 24'h050505, 24'h000000},
    '{REQ_SOLID,   24'h969696, 1'b1, 24'h969696, 24'h969696},
    // pixel 0 already sits on the palette colour, so nothing moves
    '{REQ_RAINBOW, 24'hFFFFFF, 1'b1, 24'h969696, 24'h969696},
    '{REQ_SOLID,   24'h00FF00, 1'b1, 24'h00FF00, 24'h00FF00},
    '{REQ_RAINBOW, 24'h000000, 1'b0, 24'h000000, 24'h000000},
    '{REQ_NONE,    24'h000000, 1'b0, 24'h000000, 24'h000000},
    '{REQ_SOLID,   24'hFF0000, 1'b1, 24'hFF0000, 24'hFF0000},
    '{REQ_RAINBOW, 24'hA5A5A5, 1'b0, 24'h000000, 24'h000000},
    '{REQ_RAINBOW, 24'h5A5A5A, 1'b0, 24'h000000, 24'h000000}
  };

  // predicted block state
  pixel_t                 strip_q [StripLen];
  logic [HoldWidth-1:0]   hold_count_q;
  logic [PalIdxWidth-1:0] palette_q;
  logic [ChanWidth-1:0]   fade_step_q;
  logic [ChanWidth-1:0]   hold_limit_q;

  pixel_word_t pending_pixels [$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_checked = 0;
  int unsigned frames_sent = 0;
  int unsigned solids_sent = 0;
  int unsigned clears_sent = 0;
  int unsigned unused_sent = 0;
  int unsigned settings_applied = 0;
  bit          quiet = 1'b0;

  function automatic logic [7:0] fade_towards(input logic [7:0] cur, input logic [7:0] target);
    int c;
    c = cur;
    if (c + int'(fade_step_q) < int'(target)) c = c + int'(fade_step_q);
    if (c > int'(target) + int'(fade_step_q)) c = c - int'(fade_step_q);
    return 8'(c);
  endfunction

  // update the predicted strip for one accepted request and queue its frame
  function automatic void advance_strip(input strip_req_t rq);
    pixel_t      target;
    pixel_word_t w;
    case (rq.kind)
      REQ_CLEAR: begin
        foreach (strip_q[i]) strip_q[i] = '0;
      end
      REQ_RAINBOW: begin
        for (int i = StripLen - 1; i > 0; i--) strip_q[i] = strip_q[i-1];
        if (hold_count_q > hold_limit_q) begin
          palette_q++;
          hold_count_q = '0;
        end
        hold_count_q++;
        target = palette_colours[palette_q];
        strip_q[0].red   = fade_towards(strip_q[0].red, target.red);
        strip_q[0].green = fade_towards(strip_q[0].green, target.green);
        strip_q[0].blue  = fade_towards(strip_q[0].blue, target.blue);
      end
      REQ_SOLID: begin
        foreach (strip_q[i]) strip_q[i] = rq.fill;
      end
      default: ;
    endcase
    if (rq.kind == REQ_RAINBOW || rq.kind == REQ_SOLID) begin
      for (int i = 0; i < StripLen; i++) begin
        w.index     = IndexWidth'(i);
        w.colour    = rq.typed ? ((i == 0) ? rq.head : rq.tail) : strip_q[i];
        w.frame_end = (i == StripLen - 1);
        pending_pixels.push_back(w);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // pixel words: check against the oldest prediction, then pick next ready
  always @(posedge clk_i) begin : pixel_check
    pixel_word_t want;
    if (rst_ni && pix_bus.valid && pix_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel word with none expected: index %0d", pix_bus.pixel_index);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_index", 8'(want.index), 8'(pix_bus.pixel_index));
        check_field("pixel_red", want.colour.red, pix_bus.pixel_red);
        check_field("pixel_green", want.colour.green, pix_bus.pixel_green);
        check_field("pixel_blue", want.colour.blue, pix_bus.pixel_blue);
        check_field("frame_end", 8'(want.frame_end), 8'(pix_bus.frame_end));
        words_checked++;
      end
    end
    pix_bus.ready <= quiet || ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Run stopped at cycle limit %0d", CycleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input strip_req_t rq);
    while (!quiet && $urandom_range(99) < 6) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= rq.kind;
    req_bus.fill_red   <= rq.fill.red;
    req_bus.fill_green <= rq.fill.green;
    req_bus.fill_blue  <= rq.fill.blue;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    advance_strip(rq);
    case (rq.kind)
      REQ_CLEAR:   clears_sent++;
      REQ_RAINBOW: frames_sent++;
      REQ_SOLID: begin
        frames_sent++;
        solids_sent++;
      end
      default:     unused_sent++;
    endcase
  endtask

  // hold off until every pixel word is back and the block has settled
  task automatic drain_strip();
    req_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [7:0] fade, input logic [7:0] hold);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_FADE_STEP;
    cfg_data_i <= fade;
    @(posedge clk_i);
    fade_step_q = fade;
    cfg_idx_i  <= REG_HOLD_LIMIT;
    cfg_data_i <= hold;
    @(posedge clk_i);
    hold_limit_q = hold;
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic run_phase(input logic [7:0] fade, input logic [7:0] hold,
                           input int unsigned items, input bit calm);
    int unsigned done;
    int unsigned pick;
    logic [31:0] rnd;
    strip_req_t  rq;
    drain_strip();
    apply_setting(fade, hold);
    quiet = calm;
    done  = 0;
    while (done < items) begin
      pick = $urandom_range(99);
      rnd  = $urandom;
      rq   = '{REQ_NONE, rnd[23:0], 1'b0, 24'h000000, 24'h000000};
      // mostly rainbow steps so the fade and palette walk get far
      rq.kind = (pick < 80) ? REQ_RAINBOW :
                (pick < 90) ? REQ_SOLID :
                (pick < 95) ? REQ_CLEAR : REQ_NONE;
      send_item(rq);
      if (rq.kind != REQ_NONE) done++;
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    rst_ni             <= 1'b0;
    req_bus.valid      <= 1'b0;
    req_bus.req_type   <= REQ_NONE;
    req_bus.fill_red   <= '0;
    req_bus.fill_green <= '0;
    req_bus.fill_blue  <= '0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_FADE_STEP;
    cfg_data_i         <= '0;
    foreach (strip_q[i]) strip_q[i] = '0;
    hold_count_q = '0;
    palette_q    = '0;
    fade_step_q  = FadeStepReset;
    hold_limit_q = HoldLimitReset;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (chase_table[r]) send_item(chase_table[r]);

    run_phase(8'd255, 8'd0, 40, 1'b0);
    run_phase(8'd0, 8'd7, 40, 1'b1);
    // hold limit 255 needs the hold count to pass 255 before the palette moves on
    run_phase(8'd9, 8'd255, 320, 1'b0);
    run_phase(8'd1, 8'd3, 50, 1'b0);
    run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(255)), 50, 1'b0);

    drain_strip();
    repeat (StripLen + 10) @(posedge clk_i);

    $display("Sent %0d frames (%0d solid fills), %0d clears and %0d unused requests over %0d",
             frames_sent, solids_sent, clears_sent, unused_sent, settings_applied);
    $display("register settings; %0d pixel words checked, %0d mismatches.",
             words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[led_strip_fading_color_chase_top.f]
src/lsfcc_pkg.sv
src/lsfcc_if.sv
src/lsfcc_ctrl.sv
src/lsfcc_dp.sv
src/led_strip_fading_color_chase_top.sv
bench/testbench.sv
